>>> hdl/etfi_pkg.sv
// Shared constants, types and helpers for the escape-time fractal iterator.
`default_nettype none

package etfi_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = 16;
  localparam int POW_W  = 4;
  localparam int BAIL_W = 31;
  localparam int PROD_W = 2 * WORD_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam int DEF_FRAC_BITS = 28;
  localparam int DEF_MAX_POWER = 8;
  localparam int MIN_POWER     = 2;

  localparam logic [POW_W-1:0]  RST_POWER    = POW_W'(2);
  localparam logic [CNT_W-1:0]  RST_MAX_ITER = CNT_W'(255);
  localparam logic [BAIL_W-1:0] RST_BAILOUT  = BAIL_W'(1073741824);

  localparam logic [1:0] REG_POWER    = 2'd0;
  localparam logic [1:0] REG_MAX_ITER = 2'd1;
  localparam logic [1:0] REG_BAILOUT  = 2'd2;

  typedef struct packed {
    logic load;
    logic mul;
    logic k_init;
    logic acc;
    logic add;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic below;
    logic more;
    logic limit;
    logic out_free;
  } status_t;

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-WORD_W:0] hi;
    hi = v[SUM_W-1:WORD_W-1];
    if ((&hi) || !(|hi)) begin
      sat_word = v[WORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      sat_word = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      sat_word = {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

>>> hdl/etfi_if.sv
// Valid/ready channel interfaces for points in and escape results out.
`default_nettype none

interface etfi_point_if import etfi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] start_re;
  logic signed [WORD_W-1:0] start_im;
  logic signed [WORD_W-1:0] offset_re;
  logic signed [WORD_W-1:0] offset_im;

  modport source (output valid, start_re, start_im, offset_re, offset_im, input ready);
  modport sink   (input valid, start_re, start_im, offset_re, offset_im, output ready);
endinterface

interface etfi_result_if import etfi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CNT_W-1:0]         iteration_count;
  logic                     escaped;
  logic signed [WORD_W-1:0] final_re;
  logic signed [WORD_W-1:0] final_im;

  modport source (output valid, iteration_count, escaped, final_re, final_im, input ready);
  modport sink   (input valid, iteration_count, escaped, final_re, final_im, output ready);
endinterface

`default_nettype wire

>>> hdl/etfi_regs.sv
// APB configuration registers: power, iteration limit, bailout squared.
`default_nettype none

module etfi_regs import etfi_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic      [POW_W-1:0]  power,
  output logic      [CNT_W-1:0]  max_iterations,
  output logic      [BAIL_W-1:0] bailout_squared
);

  logic       wr_en;
  logic [1:0] index;

  assign pready = 1'b1;
  assign index  = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      power           <= RST_POWER;
      max_iterations  <= RST_MAX_ITER;
      bailout_squared <= RST_BAILOUT;
    end else if (wr_en) begin
      unique case (index)
        REG_POWER:    power           <= pwdata[POW_W-1:0];
        REG_MAX_ITER: max_iterations  <= pwdata[CNT_W-1:0];
        REG_BAILOUT:  bailout_squared <= pwdata[BAIL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_POWER:    prdata = DATA_W'(power);
      REG_MAX_ITER: prdata = DATA_W'(max_iterations);
      REG_BAILOUT:  prdata = DATA_W'(bailout_squared);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/etfi_ctrl.sv
// Iteration sequencer: issues load, multiply, accumulate, add and emit commands.
`default_nettype none

module etfi_ctrl import etfi_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output cmd_t         cmd,
  input  wire status_t status
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQR  = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_ADD  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SQR;
        end
      end
      S_SQR: begin
        cmd.mul    = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (status.below) begin
          cmd.k_init = 1'b1;
          state_next = S_ACC;
        end else begin
          state_next = S_DONE;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = status.more ? S_MUL : S_ADD;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = status.limit ? S_DONE : S_SQR;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/etfi_dp.sv
// Fixed-point datapath: complex products, saturation, bailout test, counters, result register.
`default_nettype none

module etfi_dp import etfi_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int MAX_POWER = DEF_MAX_POWER
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cmd_t                     cmd,
  output status_t                       status,
  input  wire logic signed [WORD_W-1:0] start_re,
  input  wire logic signed [WORD_W-1:0] start_im,
  input  wire logic signed [WORD_W-1:0] offset_re,
  input  wire logic signed [WORD_W-1:0] offset_im,
  input  wire logic        [POW_W-1:0]  power,
  input  wire logic        [CNT_W-1:0]  max_iterations,
  input  wire logic        [BAIL_W-1:0] bailout_squared,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic             [CNT_W-1:0]  out_count,
  output logic                          out_escaped,
  output logic signed      [WORD_W-1:0] out_re,
  output logic signed      [WORD_W-1:0] out_im
);

  localparam int PW = $clog2(MAX_POWER + 1);

  logic signed [WORD_W-1:0] zr, zi, cr, ci, wr, wi;
  logic signed [PROD_W-1:0] pac, pbd, pad, pbc;
  logic signed [SUM_W-1:0]  re_sum, im_sum, mag_sum, re_shr, im_shr;
  logic        [SUM_W-1:0]  mag_shr;
  logic signed [SUM_W-1:0]  add_re, add_im;
  logic signed [WORD_W-1:0] new_re, new_im;
  logic        [PW-1:0]     k, k_inc, p_eff;
  logic        [CNT_W:0]    n, n_inc;
  logic                     esc;

  always_comb begin
    if (int'(power) < MIN_POWER) begin
      p_eff = PW'(MIN_POWER);
    end else if (int'(power) > MAX_POWER) begin
      p_eff = PW'(MAX_POWER);
    end else begin
      p_eff = PW'(power);
    end
  end

  assign re_sum  = SUM_W'(pac) - SUM_W'(pbd);
  assign im_sum  = SUM_W'(pad) + SUM_W'(pbc);
  assign mag_sum = SUM_W'(pac) + SUM_W'(pbd);
  assign re_shr  = re_sum >>> FRAC_BITS;
  assign im_shr  = im_sum >>> FRAC_BITS;
  assign mag_shr = mag_sum >>> FRAC_BITS;

  assign add_re = SUM_W'(wr) + SUM_W'(cr);
  assign add_im = SUM_W'(wi) + SUM_W'(ci);
  assign new_re = sat_word(add_re);
  assign new_im = sat_word(add_im);

  assign k_inc = k + PW'(1);
  assign n_inc = n + (CNT_W + 1)'(1);

  assign status.below    = mag_shr < SUM_W'(bailout_squared);
  assign status.more     = k_inc < p_eff;
  assign status.limit    = n_inc > {1'b0, max_iterations};
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      zr <= start_re;
      zi <= start_im;
      wr <= start_re;
      wi <= start_im;
      cr <= offset_re;
      ci <= offset_im;
    end else if (cmd.acc) begin
      wr <= sat_word(re_shr);
      wi <= sat_word(im_shr);
    end else if (cmd.add) begin
      zr <= new_re;
      zi <= new_im;
      wr <= new_re;
      wi <= new_im;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pac <= wr * zr;
      pbd <= wi * zi;
      pad <= wr * zi;
      pbc <= wi * zr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k   <= '0;
      n   <= '0;
      esc <= 1'b0;
    end else begin
      if (cmd.k_init) begin
        k <= PW'(1);
      end else if (cmd.acc) begin
        k <= k_inc;
      end
      if (cmd.load) begin
        n   <= '0;
        esc <= 1'b1;
      end else if (cmd.add) begin
        if (status.limit) begin
          n   <= {1'b0, max_iterations};
          esc <= 1'b0;
        end else begin
          n <= n_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_count   <= n[CNT_W-1:0];
      out_escaped <= esc;
      out_re      <= zr;
      out_im      <= zi;
    end
  end

endmodule

`default_nettype wire

>>> hdl/escape_time_fractal_iterator.sv
// Top level of the escape-time fractal iterator (Mandelbrot/Julia, integer power).
//
//   port      dir   kind           moves
//   point     in    valid/ready    start z and constant c, signed Q4.28
//   result    out   valid/ready    iteration count, escaped flag, final z
//   APB       in    psel/penable   power, max_iterations, bailout_squared
//
// One point is worked at a time: it is loaded, then each iteration runs a squaring multiply
// and its bailout test, accumulate and multiply steps up to the clamped power P and the add
// of c; an escaping point ends on a final test, and hand-off waits for a free output register.
// The four shared 32x32 multipliers and their product register set the pace of an iteration.
// Reset is synchronous and returns the registers to power 2, limit 255, bailout 4.0.
// A finished result waits in its output register; a new point is taken meanwhile.
`default_nettype none

module escape_time_fractal_iterator import etfi_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int MAX_POWER = DEF_MAX_POWER
) (
  input  wire logic              clk,
  input  wire logic              rst,
  etfi_point_if.sink             point,
  etfi_result_if.source          result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cmd_t              cmd;
  status_t           status;
  logic [POW_W-1:0]  power;
  logic [CNT_W-1:0]  max_iterations;
  logic [BAIL_W-1:0] bailout_squared;

  etfi_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .power           (power),
    .max_iterations  (max_iterations),
    .bailout_squared (bailout_squared)
  );

  etfi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (point.valid),
    .in_ready (point.ready),
    .cmd      (cmd),
    .status   (status)
  );

  etfi_dp #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_POWER (MAX_POWER)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .start_re        (point.start_re),
    .start_im        (point.start_im),
    .offset_re       (point.offset_re),
    .offset_im       (point.offset_im),
    .power           (power),
    .max_iterations  (max_iterations),
    .bailout_squared (bailout_squared),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .out_count       (result.iteration_count),
    .out_escaped     (result.escaped),
    .out_re          (result.final_re),
    .out_im          (result.final_im)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    point.valid && point.ready |=> !point.ready)
    else $error("point accepted while another is in flight");

  a_limit_count: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.escaped |-> result.iteration_count == max_iterations)
    else $error("non-escaped result count differs from iteration limit");

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("result emitted over an unconsumed result");

endmodule

`default_nettype wire

>>> bench/tb.sv
// Testbench for the escape-time fractal iterator: directed and random points checked by a scoreboard.
`timescale 1ns / 1ps

module tb;
  import etfi_pkg::*;

  localparam int FRAC          = DEF_FRAC_BITS;
  localparam int ONE           = 1 << FRAC;
  localparam int LIMIT_CYCLES  = 3_000_000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_POINTS  = 65;
  localparam int LONG_HOLD     = 2000;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam logic signed [WORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [WORD_W-1:0] start_re;
    logic signed [WORD_W-1:0] start_im;
    logic signed [WORD_W-1:0] offset_re;
    logic signed [WORD_W-1:0] offset_im;
  } point_t;

  typedef struct packed {
    logic [CNT_W-1:0]         iteration_count;
    logic                     escaped;
    logic signed [WORD_W-1:0] final_re;
    logic signed [WORD_W-1:0] final_im;
  } result_t;

  class escape_scoreboard;
    logic [POW_W-1:0]  power;
    logic [CNT_W-1:0]  max_iterations;
    logic [BAIL_W-1:0] bailout_sq;
    result_t           expected_escapes[$];
    int                errors;

    function new();
      power          = RST_POWER;
      max_iterations = RST_MAX_ITER;
      bailout_sq     = RST_BAILOUT;
      errors         = 0;
    endfunction

    function void write_register(logic [1:0] index, logic [DATA_W-1:0] value);
      case (index)
        REG_POWER:    power = value[POW_W-1:0];
        REG_MAX_ITER: max_iterations = value[CNT_W-1:0];
        REG_BAILOUT:  bailout_sq = value[BAIL_W-1:0];
        default: ;
      endcase
    endfunction

    static function longint clip(longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
    endfunction

    static function longint unsigned magnitude_sq(longint re, longint im);
      longint unsigned ar, ai;
      ar = (re < 0) ? -re : re;
      ai = (im < 0) ? -im : im;
      return (ar * ar + ai * ai) >> FRAC;
    endfunction

    function void note_point(point_t pt);
      longint      zr, zi, cr, ci, wr, wi, tr, ti;
      int unsigned exponent, count, k;
      bit          escaped;
      result_t     r;
      zr = pt.start_re;
      zi = pt.start_im;
      cr = pt.offset_re;
      ci = pt.offset_im;
      exponent = power;
      if (exponent < MIN_POWER) exponent = MIN_POWER;
      if (exponent > DEF_MAX_POWER) exponent = DEF_MAX_POWER;
      count   = 0;
      escaped = 1'b1;
      while (magnitude_sq(zr, zi) < bailout_sq) begin
        wr = zr;
        wi = zi;
        for (k = 1; k < exponent; k++) begin
          tr = clip((wr * zr - wi * zi) >>> FRAC);
          ti = clip((wr * zi + wi * zr) >>> FRAC);
          wr = tr;
          wi = ti;
        end
        zr = clip(wr + cr);
        zi = clip(wi + ci);
        count++;
        if (count > max_iterations) begin
          count   = max_iterations;
          escaped = 1'b0;
          break;
        end
      end
      r.iteration_count = count[CNT_W-1:0];
      r.escaped         = escaped;
      r.final_re        = zr[WORD_W-1:0];
      r.final_im        = zi[WORD_W-1:0];
      expected_escapes.push_back(r);
    endfunction

    function void compare_field(string name, logic signed [WORD_W:0] want,
                                logic signed [WORD_W:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_escapes.size() == 0) begin
        $error("result with no point outstanding: iteration_count %0d", got.iteration_count);
        errors++;
        return;
      end
      want = expected_escapes.pop_front();
      compare_field("iteration_count", want.iteration_count, got.iteration_count);
      compare_field("escaped", want.escaped, got.escaped);
      compare_field("final_re", want.final_re, got.final_re);
      compare_field("final_im", want.final_im, got.final_im);
    endfunction

    function int outstanding();
      return expected_escapes.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  etfi_point_if  point_ch();
  etfi_result_if result_ch();

  escape_scoreboard board = new();
  bit               idling;
  int               hold_request;

  escape_time_fractal_iterator DUT (
    .clk     (clk),
    .rst     (rst),
    .point   (point_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    int cycles_run;
    for (cycles_run = 0; cycles_run < LIMIT_CYCLES; cycles_run++) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  initial begin : result_sink
    int stall;
    stall = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end else if (stall == 0 && idling && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 6);
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        stall--;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      board.check_result(result_t'{result_ch.iteration_count, result_ch.escaped,
                                   result_ch.final_re, result_ch.final_im});
    end
  end

  task automatic write_register(logic [1:0] index, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.write_register(index, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_point(point_t pt);
    int gap;
    if (idling && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      point_ch.valid <= 1'b0;
      {point_ch.start_re, point_ch.start_im, point_ch.offset_re, point_ch.offset_im}
        <= {$urandom, $urandom, $urandom, $urandom};
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    point_ch.valid <= 1'b1;
    {point_ch.start_re, point_ch.start_im, point_ch.offset_re, point_ch.offset_im} <= pt;
    do @(posedge clk); while (!point_ch.ready);
    board.note_point(pt);
  endtask

  task automatic drain();
    @(negedge clk);
    point_ch.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  function automatic point_t make_point(logic signed [WORD_W-1:0] zr, logic signed [WORD_W-1:0] zi,
                                        logic signed [WORD_W-1:0] cr, logic signed [WORD_W-1:0] ci);
    return point_t'{zr, zi, cr, ci};
  endfunction

  function automatic logic signed [WORD_W-1:0] spread(int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic point_t random_point();
    point_t      pt;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: pt = make_point(0, 0, spread(2 * ONE), spread(2 * ONE));
      4, 5, 6:    pt = make_point(spread(2 * ONE), spread(2 * ONE), spread(ONE), spread(ONE));
      7:          pt = make_point(spread(1 << 22), spread(1 << 22), spread(1 << 24),
                                  spread(1 << 24));
      default:    pt = point_t'({$urandom, $urandom, $urandom, $urandom});
    endcase
    return pt;
  endfunction

  initial begin : stimulus
    int          phase;
    int          n;
    int unsigned bail;
    rst     <= 1'b1;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    point_ch.valid <= 1'b0;
    {point_ch.start_re, point_ch.start_im, point_ch.offset_re, point_ch.offset_im} <= '0;
    idling       = 1'b1;
    hold_request = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: power 2, limit 255, bailout 4.0
    send_point(make_point(0, 0, 0, 0));
    send_point(make_point(0, 0, -2 * ONE, 0));
    send_point(make_point(0, 0, ONE, 0));
    send_point(make_point(Q_MIN, Q_MIN, Q_MAX, Q_MAX));
    send_point(make_point(Q_MAX, Q_MAX, Q_MIN, Q_MIN));
    send_point(make_point(0, 0, Q_MAX, Q_MIN));
    send_point(make_point(-1, 1, 0, 0));
    send_point(make_point(ONE / 2, ONE / 2, -3 * (ONE / 4), ONE / 10));
    send_point(make_point((ONE / 10) * 19, 0, Q_MAX, 0));
    drain();

    // clamp power high, widest limit and bailout, fast escapes only
    write_register(REG_POWER, 15);
    write_register(REG_MAX_ITER, 16'hFFFF);
    write_register(REG_BAILOUT, 31'h7FFF_FFFF);
    send_point(make_point(ONE + ONE / 2, 0, 0, 0));
    send_point(make_point(0, 0, 2 * ONE, 0));
    send_point(make_point(0, 0, 0, -2 * ONE));
    send_point(make_point(ONE, ONE, 0, 0));
    drain();

    // zero limit with power clamped low
    write_register(REG_POWER, 0);
    write_register(REG_MAX_ITER, 0);
    write_register(REG_BAILOUT, RST_BAILOUT);
    send_point(make_point(0, 0, ONE / 4, 0));
    send_point(make_point(3 * ONE, 0, 0, 0));
    send_point(make_point(0, 0, -2 * ONE, 0));
    drain();

    // zero bailout
    write_register(REG_POWER, 1);
    write_register(REG_MAX_ITER, 1);
    write_register(REG_BAILOUT, 0);
    send_point(make_point(0, 0, 0, 0));
    send_point(make_point(-1, -1, -1, -1));
    drain();

    // unmapped address, smallest nonzero bailout
    write_register(REG_SPARE, $urandom);
    write_register(REG_POWER, 9);
    write_register(REG_BAILOUT, 1);
    send_point(make_point(0, 0, 0, 0));
    send_point(make_point(1 << 14, 0, 0, 0));
    send_point(make_point(1 << 13, 1 << 13, 0, 0));
    drain();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      idling = (phase < RANDOM_PHASES - 2);
      write_register(REG_POWER, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                           : $urandom_range(MIN_POWER,
                                                                            DEF_MAX_POWER));
      write_register(REG_MAX_ITER, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3)
                                                               : $urandom_range(4, 32));
      case ($urandom_range(0, 4))
        0:       bail = RST_BAILOUT;
        1, 2:    bail = $urandom_range(1, 7) << FRAC;
        3:       bail = $urandom_range(1, 32'h7FFF_FFFF);
        default: bail = ($urandom_range(0, 1) == 0) ? 1 : 32'h7FFF_FFFF;
      endcase
      write_register(REG_BAILOUT, bail);
      if (phase == 2) hold_request = LONG_HOLD;
      for (n = 0; n < PHASE_POINTS; n++) begin
        if (phase == 4 && n == PHASE_POINTS / 2) drain();
        send_point(random_point());
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
